// File: hdl/assert_macros.svh
// Assertion macros for the sound unit RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: hdl/dssu_pkg.sv
// Package for the dual square wave sound unit: types, codes and constants.
// No dependencies.
package dssu_pkg;
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic [3:0] REG_NR10 = 4'd0;
  localparam logic [3:0] REG_NR11 = 4'd1;
  localparam logic [3:0] REG_NR12 = 4'd2;
  localparam logic [3:0] REG_NR13 = 4'd3;
  localparam logic [3:0] REG_NR14 = 4'd4;
  localparam logic [3:0] REG_NR21 = 4'd5;
  localparam logic [3:0] REG_NR22 = 4'd6;
  localparam logic [3:0] REG_NR23 = 4'd7;
  localparam logic [3:0] REG_NR24 = 4'd8;
  localparam logic [3:0] REG_NR50 = 4'd9;
  localparam logic [3:0] REG_NR52 = 4'd10;

  localparam logic [7:0] DUTY_PAT [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};
  localparam logic [12:0] DAC_STEP = 13'd4369;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MIX, S_OUT} state_t;

  typedef struct packed {
    logic exec;   // perform the item's state update
    logic mix;    // register the gain product
    logic load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic       div_bit;
  } item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              sample_valid;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
    logic              ch1_active;
    logic              ch2_active;
  } result_t;
endpackage

// File: hdl/dssu_if.sv
// Valid/ready channel interface carrying a payload of a given type.
// Depends on nothing but the type passed in.
interface dssu_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/dual_square_wave_sound_unit.sv
// Top level of the dual square wave sound unit: two square channels, mixer.
// The output step waits while the previous result is still held and not yet taken.
// The controller holds one item at a time: capture, execute, gain multiply,
// output. Reset (rst, synchronous) restores the post-boot register values.
// Depends on dssu_pkg, dssu_if, dssu_ctrl, dssu_dp and assert_macros.svh.
`include "assert_macros.svh"
module dual_square_wave_sound_unit import dssu_pkg::*; #(
  parameter int SAMPLE_INTERVAL = 96
) (
  input  logic        clk,
  input  logic        rst,
  dssu_if.sink        in_ch,
  dssu_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata
);
  cmd_t    cmd;
  result_t result;
  logic    in_ready;
  logic    out_valid;

  assign in_ch.ready = in_ready;

  dssu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ready),
    .out_busy(out_valid && !out_ch.ready), .cmd(cmd)
  );

  dssu_dp #(.SAMPLE_INTERVAL(SAMPLE_INTERVAL)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .capture(in_ch.valid && in_ready),
    .item_in(in_ch.data), .gain_we(cfg_we), .gain_wdata(cfg_wdata), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_ch.data <= result;
  end

  assign out_ch.valid = out_valid;

  `ASSERT_IMPL(a_load_free, clk, rst, cmd.load |-> (!out_valid || out_ch.ready), "load over held result")
  `ASSERT_IMPL(a_exec_after, clk, rst, (in_ch.valid && in_ready) |=> cmd.exec, "accept not executed")
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, cmd.exec |-> !in_ready, "accept while busy")
endmodule

// File: hdl/dssu_ctrl.sv
// Controller for the sound unit: sequences one item through execute, mix and output.
// Depends on dssu_pkg.
module dssu_ctrl import dssu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   out_busy,
  output cmd_t   cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // The result register must be free before it is loaded.
        if (!out_busy) begin
          cmd.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: hdl/dssu_dp.sv
// Datapath for the sound unit: registers, channel state, frame sequencer, mixer.
// Depends on dssu_pkg.
module dssu_dp import dssu_pkg::*; #(
  parameter int SAMPLE_INTERVAL = 96
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       capture,
  input  item_t      item_in,
  input  logic       gain_we,
  input  logic [8:0] gain_wdata,
  output result_t    result
);
  localparam int TICKS = SAMPLE_INTERVAL / 4;

  item_t       item;
  logic [8:0]  gain;
  logic [6:0]  sweep_setup;
  logic [7:0]  dl [2];
  logic [7:0]  env [2];
  logic [10:0] per [2];
  logic [1:0]  tl [2];
  logic [7:0]  mvol;
  logic [2:0]  pwr;
  logic [11:0] pcnt [2];
  logic [2:0]  dpos [2];
  logic [3:0]  vol [2];
  logic [6:0]  envl [2];
  logic [7:0]  lcnt [2];
  logic [2:0]  swc;
  logic [1:0]  dac;
  logic [2:0]  fstep;
  logic        pdiv;
  logic [9:0]  stc;
  logic [7:0]  rdata;
  logic        sv;
  logic signed [16:0] sum;
  logic signed [26:0] prod;

  // Next values, computed from the captured item.
  logic [6:0]  sweep_setup_next;
  logic [7:0]  dl_next [2];
  logic [7:0]  env_next [2];
  logic [10:0] per_next [2];
  logic [1:0]  tl_next [2];
  logic [7:0]  mvol_next;
  logic [2:0]  pwr_next;
  logic [11:0] pcnt_next [2];
  logic [2:0]  dpos_next [2];
  logic [3:0]  vol_next [2];
  logic [6:0]  envl_next [2];
  logic [7:0]  lcnt_next [2];
  logic [2:0]  swc_next;
  logic [1:0]  dac_next;
  logic [2:0]  fstep_next;
  logic        pdiv_next;
  logic [9:0]  stc_next;
  logic [7:0]  rdata_next;
  logic        sv_next;
  logic signed [16:0] sum_next;

  always_comb begin
    logic [1:0]  on;
    logic [2:0]  pace;
    logic [3:0]  sc;
    logic [11:0] np;
    logic [10:0] dlt;
    logic [2:0]  ecnt;
    logic [3:0]  lvl;
    logic signed [16:0] an;
    logic [15:0] prodl;
    sweep_setup_next = sweep_setup; dl_next = dl; env_next = env; per_next = per;
    tl_next = tl; mvol_next = mvol; pwr_next = pwr; pcnt_next = pcnt;
    dpos_next = dpos; vol_next = vol; envl_next = envl; lcnt_next = lcnt;
    swc_next = swc; dac_next = dac; fstep_next = fstep; pdiv_next = pdiv;
    stc_next = stc; rdata_next = 8'd0; sv_next = 1'b0; sum_next = '0;
    on = pwr[1:0];
    pace = '0; sc = '0; np = '0; dlt = '0; ecnt = '0; lvl = '0; an = '0; prodl = '0;
    priority if (item.func == FUNC_TICK) begin
      if (pwr[2]) begin
        if (pdiv && !item.div_bit) begin
          fstep_next = fstep + 3'd1;
          if (!fstep_next[0]) begin
            for (int c = 0; c < 2; c++) begin
              if (on[c] && tl[c][0]) begin
                lcnt_next[c] = lcnt[c] + 8'd1;
                if (lcnt_next[c] == {2'b00, dl[c][5:0]}) pwr_next[c] = 1'b0;
              end
            end
            if (fstep_next[1:0] == 2'b00) begin
              pace = sweep_setup[6:4];
              if (on[0] && pace != 3'd0) begin
                sc = {1'b0, swc} + 4'd1;
                if (sc >= {1'b0, pace}) begin
                  dlt = per[0] >> sweep_setup[2:0];
                  np = sweep_setup[3] ? {1'b0, per[0]} + {1'b0, dlt}
                                      : {1'b0, per[0]} - {1'b0, dlt};
                  if (np[11]) pwr_next[0] = 1'b0;
                  per_next[0] = np[10:0];
                  sc = 4'd0;
                end
                swc_next = sc[2:0];
              end
              if (fstep_next == 3'd0) begin
                for (int c = 0; c < 2; c++) begin
                  if (on[c] && envl[c][6:4] != 3'd0) begin
                    ecnt = envl[c][2:0] + 3'd1;
                    if (ecnt >= envl[c][6:4]) begin
                      if (envl[c][3]) begin
                        if (vol[c] != 4'hF) vol_next[c] = vol[c] + 4'd1;
                      end else if (vol[c] != 4'h0) vol_next[c] = vol[c] - 4'd1;
                      ecnt = 3'd0;
                    end
                    envl_next[c] = {envl[c][6:3], ecnt};
                  end
                end
              end
            end
          end
        end
        pdiv_next = item.div_bit;
        for (int c = 0; c < 2; c++) begin
          if (on[c]) begin
            pcnt_next[c] = pcnt[c] + 12'd1;
            if (pcnt_next[c][11]) begin
              dpos_next[c] = dpos[c] + 3'd1;
              pcnt_next[c] = {1'b0, per_next[c]};
            end
          end
        end
        stc_next = stc + 10'd1;
        if (stc_next >= 10'(TICKS)) begin
          stc_next = '0;
          sv_next = 1'b1;
          // Levels use the channel state after this tick's updates.
          for (int c = 0; c < 2; c++) begin
            lvl = (pwr_next[c] && DUTY_PAT[dl[c][7:6]][dpos_next[c]]) ? vol_next[c] : 4'd0;
            prodl = {3'b000, DAC_STEP} * {12'd0, lvl};
            an = (17'sd32767 - $signed({1'b0, prodl})) >>> 1;
            if (an < 0 && prodl[0] == 1'b0) an = an + 17'sd1;
            if (dac[c]) sum_next = sum_next + an;
          end
        end
      end
    end else if (item.func == FUNC_WRITE) begin
      unique case (item.reg_index)
        REG_NR10: sweep_setup_next = item.write_data[6:0];
        REG_NR11: dl_next[0] = item.write_data;
        REG_NR21: dl_next[1] = item.write_data;
        REG_NR13: per_next[0] = {per[0][10:8], item.write_data};
        REG_NR23: per_next[1] = {per[1][10:8], item.write_data};
        REG_NR50: mvol_next = item.write_data;
        REG_NR12, REG_NR22: begin
          for (int c = 0; c < 2; c++) begin
            if (item.reg_index == (c == 0 ? REG_NR12 : REG_NR22)) begin
              env_next[c] = item.write_data;
              dac_next[c] = item.write_data[7:3] != 5'd0;
              if (!dac_next[c]) pwr_next[c] = 1'b0;
            end
          end
        end
        REG_NR14, REG_NR24: begin
          for (int c = 0; c < 2; c++) begin
            if (item.reg_index == (c == 0 ? REG_NR14 : REG_NR24)) begin
              tl_next[c] = item.write_data[7:6];
              per_next[c] = {item.write_data[2:0], per[c][7:0]};
              if (item.write_data[7] && dac[c]) begin
                pwr_next[c] = 1'b1;
                lcnt_next[c] = '0;
                pcnt_next[c] = {1'b0, per_next[c]};
                vol_next[c] = env[c][7:4];
                envl_next[c] = {env[c][2:0], env[c][3], 3'd0};
              end
            end
          end
        end
        REG_NR52: begin
          if (item.write_data[7] != pwr[2]) begin
            if (item.write_data[7]) begin
              sweep_setup_next = '0;
              dl_next[0] = 8'hBF; dl_next[1] = 8'h3F;
              env_next[0] = 8'hF3; env_next[1] = 8'h00;
              per_next[0] = 11'd2047; per_next[1] = 11'd2047;
              tl_next[0] = 2'd2; tl_next[1] = 2'd2;
              mvol_next = 8'h77;
              pwr_next = 3'b101;
              pcnt_next[0] = 12'd2047; pcnt_next[1] = 12'd2047;
              dac_next = 2'b01;
            end else pwr_next[2] = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (item.func == FUNC_READ) begin
      unique case (item.reg_index)
        REG_NR10: rdata_next = {1'b1, sweep_setup};
        REG_NR11: rdata_next = dl[0];
        REG_NR12: rdata_next = env[0];
        REG_NR13: rdata_next = per[0][7:0];
        REG_NR14: rdata_next = {tl[0], 3'b111, per[0][10:8]};
        REG_NR21: rdata_next = dl[1];
        REG_NR22: rdata_next = env[1];
        REG_NR23: rdata_next = per[1][7:0];
        REG_NR24: rdata_next = {tl[1], 3'b111, per[1][10:8]};
        REG_NR50: rdata_next = mvol;
        REG_NR52: rdata_next = {pwr[2], 5'b11100, pwr[1:0]};
        default:  rdata_next = 8'hFF;
      endcase
    end else begin
      // The spare function code leaves all state alone.
    end
  end

  always_ff @(posedge clk) begin
    if (capture) item <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= 9'd256;
      sweep_setup <= '0;
      dl[0] <= 8'hBF; dl[1] <= 8'h3F;
      env[0] <= 8'hF3; env[1] <= 8'h00;
      per[0] <= 11'd2047; per[1] <= 11'd2047;
      tl[0] <= 2'd2; tl[1] <= 2'd2;
      mvol <= 8'h77;
      pwr <= 3'b101;
      pcnt[0] <= 12'd2047; pcnt[1] <= 12'd2047;
      dpos[0] <= '0; dpos[1] <= '0;
      vol[0] <= '0; vol[1] <= '0;
      envl[0] <= '0; envl[1] <= '0;
      lcnt[0] <= '0; lcnt[1] <= '0;
      swc <= '0;
      dac <= 2'b01;
      fstep <= '0;
      pdiv <= 1'b0;
      stc <= '0;
    end else begin
      if (gain_we) gain <= gain_wdata;
      if (cmd.exec) begin
        sweep_setup <= sweep_setup_next; dl <= dl_next; env <= env_next;
        per <= per_next; tl <= tl_next; mvol <= mvol_next; pwr <= pwr_next;
        pcnt <= pcnt_next; dpos <= dpos_next; vol <= vol_next; envl <= envl_next;
        lcnt <= lcnt_next; swc <= swc_next; dac <= dac_next; fstep <= fstep_next;
        pdiv <= pdiv_next; stc <= stc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata <= rdata_next;
      sv <= sv_next;
      sum <= sum_next;
    end
    if (cmd.mix) prod <= sum * $signed({1'b0, gain});
  end

  // Gain divide, saturation and master volume scaling.
  always_comb begin
    logic signed [26:0] g;
    logic signed [15:0] gs;
    logic signed [19:0] l;
    logic signed [19:0] r;
    g = prod >>> 8;
    if (prod < 0 && prod[7:0] != 8'd0) g = g + 27'sd1;
    if (g > 27'sd32767) gs = 16'sd32767;
    else if (g < -27'sd32768) gs = -16'sd32768;
    else gs = g[15:0];
    l = gs * $signed({2'b00, 3'd1} + {2'b00, mvol[6:4]});
    r = gs * $signed({2'b00, 3'd1} + {2'b00, mvol[2:0]});
    l = (l < 0 && l[2:0] != 3'd0) ? (l >>> 3) + 20'sd1 : (l >>> 3);
    r = (r < 0 && r[2:0] != 3'd0) ? (r >>> 3) + 20'sd1 : (r >>> 3);
    result.read_data    = rdata;
    result.sample_valid = sv;
    result.sample_left  = sv ? l[15:0] : 16'sd0;
    result.sample_right = sv ? r[15:0] : 16'sd0;
    result.ch1_active   = pwr[0];
    result.ch2_active   = pwr[1];
  end
endmodule

// File: tb/sv/dssu_checker.sv
`timescale 1ns / 1ps
// Checker for the dual square wave sound unit: watches both channels and the gain port.
// Predicts each result from its own copy of the unit's state. Depends on dssu_pkg and dssu_if.
module dssu_checker import dssu_pkg::*; (
  input  logic clk,
  input  logic rst,
  dssu_if      item_mon,
  dssu_if      result_mon,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  output int         mismatches,
  output int         outstanding
);
  localparam int TICKS_PER_SAMPLE = 96 / 4;

  logic [8:0]  gain;
  logic [6:0]  sweep_cfg;
  logic [7:0]  duty_len [2];
  logic [7:0]  env_cfg [2];
  logic [10:0] period [2];
  logic [1:0]  trig_len [2];
  logic [7:0]  master_vol;
  logic [2:0]  power_chan;
  logic [11:0] period_cnt [2];
  logic [2:0]  duty_pos [2];
  logic [3:0]  volume [2];
  logic [6:0]  env_run [2];
  logic [7:0]  length_cnt [2];
  logic [2:0]  sweep_cnt;
  logic        dac [2];
  logic [2:0]  frame;
  logic        prev_div;
  logic [9:0]  tick_cnt;

  result_t expected_results [$];

  function automatic void load_boot_values();
    sweep_cfg = '0;
    duty_len[0] = 8'hBF; duty_len[1] = 8'h3F;
    env_cfg[0] = 8'hF3; env_cfg[1] = 8'h00;
    period[0] = 11'd2047; period[1] = 11'd2047;
    trig_len[0] = 2'd2; trig_len[1] = 2'd2;
    master_vol = 8'h77;
    power_chan = 3'd5;
    period_cnt[0] = 12'd2047; period_cnt[1] = 12'd2047;
    dac[0] = 1'b1; dac[1] = 1'b0;
  endfunction

  function automatic void reset_model();
    gain = 9'd256;
    load_boot_values();
    for (int c = 0; c < 2; c++) begin
      duty_pos[c] = '0; volume[c] = '0; env_run[c] = '0; length_cnt[c] = '0;
    end
    sweep_cnt = '0; frame = '0; prev_div = 1'b0; tick_cnt = '0;
  endfunction

  function automatic void step_envelope(int c, logic was_on);
    logic [2:0] pace;
    logic [3:0] cnt;
    pace = env_run[c][6:4];
    if (!was_on || pace == 0) return;
    cnt = {1'b0, env_run[c][2:0]} + 4'd1;
    if (cnt >= pace) begin
      if (env_run[c][3]) begin
        if (volume[c] < 4'd15) volume[c]++;
      end else if (volume[c] > 0) begin
        volume[c]--;
      end
      cnt = '0;
    end
    env_run[c] = {env_run[c][6:3], cnt[2:0]};
  endfunction

  function automatic int channel_dac(int c);
    int lvl;
    lvl = 0;
    if (power_chan[c] && DUTY_PAT[duty_len[c][7:6]][duty_pos[c]]) lvl = volume[c];
    if (!dac[c]) return 0;
    return (32767 - 4369 * lvl) / 2;
  endfunction

  function automatic int master_scale(int x, logic [2:0] mv);
    return x * (int'(mv) + 1) / 8;
  endfunction

  function automatic void advance_tick(logic div, inout result_t r);
    logic on [2];
    logic [3:0] scnt;
    int p, np, sum, g;
    on[0] = power_chan[0]; on[1] = power_chan[1];
    if (prev_div && !div) begin
      frame = frame + 3'd1;
      if (!frame[0]) begin
        for (int c = 0; c < 2; c++) begin
          if (on[c] && trig_len[c][0]) begin
            length_cnt[c] = length_cnt[c] + 8'd1;
            if (length_cnt[c] == {2'b00, duty_len[c][5:0]}) power_chan[c] = 1'b0;
          end
        end
        if (frame[1:0] == 2'd0) begin
          if (on[0] && sweep_cfg[6:4] != 0) begin
            scnt = {1'b0, sweep_cnt} + 4'd1;
            if (scnt >= sweep_cfg[6:4]) begin
              p = period[0];
              np = sweep_cfg[3] ? p + (p >> sweep_cfg[2:0]) : p - (p >> sweep_cfg[2:0]);
              // A negative result wraps like the unsigned arithmetic of the original.
              if (np >= 2048 || np < 0) power_chan[0] = 1'b0;
              period[0] = np[10:0];
              scnt = '0;
            end
            sweep_cnt = scnt[2:0];
          end
          if (frame == 3'd0) begin
            step_envelope(0, on[0]);
            step_envelope(1, on[1]);
          end
        end
      end
    end
    prev_div = div;
    for (int c = 0; c < 2; c++) begin
      if (on[c]) begin
        period_cnt[c] = period_cnt[c] + 12'd1;
        if (period_cnt[c] >= 12'd2048) begin
          duty_pos[c] = duty_pos[c] + 3'd1;
          period_cnt[c] = {1'b0, period[c]};
        end
      end
    end
    tick_cnt = tick_cnt + 10'd1;
    if (tick_cnt >= TICKS_PER_SAMPLE) begin
      sum = channel_dac(0) + channel_dac(1);
      g = sum * int'(gain) / 256;
      if (g > 32767) g = 32767;
      if (g < -32768) g = -32768;
      tick_cnt = '0;
      r.sample_valid = 1'b1;
      r.sample_left = 16'(master_scale(g, master_vol[6:4]));
      r.sample_right = 16'(master_scale(g, master_vol[2:0]));
    end
  endfunction

  function automatic void write_control(int c, logic [7:0] v);
    trig_len[c] = v[7:6];
    period[c] = {v[2:0], period[c][7:0]};
    if (v[7] && dac[c]) begin
      power_chan[c] = 1'b1;
      length_cnt[c] = '0;
      period_cnt[c] = {1'b0, period[c]};
      volume[c] = env_cfg[c][7:4];
      env_run[c] = {env_cfg[c][2:0], env_cfg[c][3], 3'd0};
    end
  endfunction

  function automatic void write_envelope(int c, logic [7:0] v);
    env_cfg[c] = v;
    dac[c] = v[7:3] != 0;
    if (!dac[c]) power_chan[c] = 1'b0;
  endfunction

  function automatic void write_register(logic [3:0] idx, logic [7:0] v);
    case (idx)
      REG_NR10: sweep_cfg = v[6:0];
      REG_NR11: duty_len[0] = v;
      REG_NR12: write_envelope(0, v);
      REG_NR13: period[0][7:0] = v;
      REG_NR14: write_control(0, v);
      REG_NR21: duty_len[1] = v;
      REG_NR22: write_envelope(1, v);
      REG_NR23: period[1][7:0] = v;
      REG_NR24: write_control(1, v);
      REG_NR50: master_vol = v;
      REG_NR52: begin
        if (v[7] != power_chan[2]) begin
          if (v[7]) load_boot_values();
          else power_chan[2] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] read_register(logic [3:0] idx);
    case (idx)
      REG_NR10: return {1'b1, sweep_cfg};
      REG_NR11: return duty_len[0];
      REG_NR12: return env_cfg[0];
      REG_NR13: return period[0][7:0];
      REG_NR14: return {trig_len[0], 3'b111, period[0][10:8]};
      REG_NR21: return duty_len[1];
      REG_NR22: return env_cfg[1];
      REG_NR23: return period[1][7:0];
      REG_NR24: return {trig_len[1], 3'b111, period[1][10:8]};
      REG_NR50: return master_vol;
      REG_NR52: return {power_chan[2], 5'b11100, power_chan[1:0]};
      default:  return 8'hFF;
    endcase
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    r = '0;
    case (it.func)
      FUNC_TICK:  if (power_chan[2]) advance_tick(it.div_bit, r);
      FUNC_WRITE: write_register(it.reg_index, it.write_data);
      FUNC_READ:  r.read_data = read_register(it.reg_index);
      default: ;
    endcase
    r.ch1_active = power_chan[0];
    r.ch2_active = power_chan[1];
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Everything is sampled on the falling edge, where it holds the values that the
  // next rising edge will act on.
  always @(negedge clk) begin
    item_t   it;
    result_t got, want;
    if (rst) begin
      reset_model();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) gain = cfg_wdata;
      if (item_mon.valid && item_mon.ready) begin
        it = item_mon.data;
        expected_results.push_back(predict_result(it));
      end
      if (result_mon.valid && result_mon.ready) begin
        got = result_mon.data;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transaction with none expected", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("sample_valid", want.sample_valid, got.sample_valid);
          check_field("sample_left", want.sample_left, got.sample_left);
          check_field("sample_right", want.sample_right, got.sample_right);
          check_field("ch1_active", want.ch1_active, got.ch1_active);
          check_field("ch2_active", want.ch2_active, got.ch2_active);
        end
      end
    end
    outstanding = expected_results.size();
  end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the sound unit testbench: clock, reset, stimulus and verdict.
// Depends on dssu_pkg, dssu_if, dssu_checker and the unit itself.
module tb;
  import dssu_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [8:0] cfg_wdata;
  int         mismatches;
  int         outstanding;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         tick_serial;
  int         div_shift;

  dssu_if #(.T(item_t))   in_ch (clk);
  dssu_if #(.T(result_t)) out_ch (clk);

  dual_square_wave_sound_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  dssu_checker u_checker (
    .clk(clk), .rst(rst), .item_mon(in_ch), .result_mon(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic [1:0] func, logic [3:0] idx, logic [7:0] data, logic div);
    item_t it;
    logic  taken;
    it = '{func: func, reg_index: idx, write_data: data, div_bit: div};
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_tick();
    tick_serial++;
    send_item(FUNC_TICK, 4'($urandom), 8'($urandom), 1'((tick_serial >> div_shift) & 1));
  endtask

  task automatic set_gain(logic [8:0] g);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) begin
      if ($urandom_range(99) == 0) div_shift = $urandom_range(3);
      send_tick();
    end else if (roll < 76) begin
      // Trigger one of the two channels, with the length counter enable bit set at random.
      send_item(FUNC_WRITE, $urandom_range(1) ? REG_NR14 : REG_NR24, 8'($urandom) | 8'h80, 1'b0);
    end else if (roll < 86) begin
      send_item(FUNC_WRITE, 4'($urandom_range(15)), 8'($urandom), 1'($urandom));
    end else if (roll < 97) begin
      send_item(FUNC_READ, 4'($urandom_range(15)), 8'($urandom), 1'($urandom));
    end else begin
      send_item(FUNC_SPARE, 4'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    send_idle_pct = 30;
    recv_idle_pct = 47;
    tick_serial = 0;
    div_shift = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cfg_we <= 1'b1;
    cfg_wdata <= 9'd1;
    @(posedge clk);
    cfg_we <= 1'b0;

    // Directed: boot register contents, unused index, spare function code,
    // power cycling, sweep overflow and a short length expiry.
    for (int r = 0; r <= 10; r++) send_item(FUNC_READ, 4'(r), 8'h00, 1'b0);
    send_item(FUNC_READ, 4'd15, 8'hFF, 1'b1);
    send_item(FUNC_WRITE, 4'd12, 8'hFF, 1'b1);
    send_item(FUNC_SPARE, 4'd15, 8'hFF, 1'b1);
    send_item(FUNC_WRITE, REG_NR52, 8'h00, 1'b0);
    send_item(FUNC_TICK, REG_NR10, 8'h00, 1'b1);
    send_item(FUNC_WRITE, REG_NR10, 8'h7F, 1'b0);
    send_item(FUNC_WRITE, REG_NR52, 8'hFF, 1'b0);
    send_item(FUNC_WRITE, REG_NR10, 8'h19, 1'b0);
    send_item(FUNC_WRITE, REG_NR11, 8'hC2, 1'b0);
    send_item(FUNC_WRITE, REG_NR14, 8'hC7, 1'b0);
    send_item(FUNC_WRITE, REG_NR50, 8'h70, 1'b0);
    repeat (120) send_tick();

    set_gain(9'd256);
    repeat (490) random_item();

    send_idle_pct = 47;
    recv_idle_pct = 30;
    set_gain(9'd0);
    repeat (490) random_item();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_gain(9'($urandom_range(256)));
    repeat (490) random_item();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** dual_square_wave_sound_unit: PASSED **");
    end else begin
      $display("** dual_square_wave_sound_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** dual_square_wave_sound_unit: FAILED **");
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/dssu_pkg.sv
hdl/dssu_if.sv
hdl/dssu_ctrl.sv
hdl/dssu_dp.sv
hdl/dual_square_wave_sound_unit.sv
tb/sv/dssu_checker.sv
tb/sv/tb.sv
